// File: rtl/chip8_instruction_execute_unit_assert.svh
// Assertion macros for the instruction execute unit
`ifndef CHIP8_INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// clocked check, disabled while reset is high
`define CHIP8_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check that also holds during reset
`define CHIP8_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CHIP8_ASSERT_CLK(label, prop, msg)
`define CHIP8_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: rtl/chip8ie_pkg.sv
// Types and constants shared by the instruction execute unit
`timescale 1ns / 1ps
package chip8ie_pkg;

   // opcode high nibble
   typedef enum logic [3:0] {
      OP_SYS     = 4'h0,
      OP_JP      = 4'h1,
      OP_CALL    = 4'h2,
      OP_SE_IMM  = 4'h3,
      OP_SNE_IMM = 4'h4,
      OP_SE_REG  = 4'h5,
      OP_LD_IMM  = 4'h6,
      OP_ADD_IMM = 4'h7,
      OP_ALU     = 4'h8,
      OP_SNE_REG = 4'h9,
      OP_LD_I    = 4'hA,
      OP_JP_V0   = 4'hB,
      OP_RND     = 4'hC,
      OP_DRW     = 4'hD,
      OP_KEY     = 4'hE,
      OP_MISC    = 4'hF
   } op_group_type;

   // 8XYN sub-operations
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // low-byte selectors
   localparam logic [7:0] NN_CLS      = 8'hE0;
   localparam logic [7:0] NN_SKP      = 8'h9E;
   localparam logic [7:0] NN_SKNP     = 8'hA1;
   localparam logic [7:0] NN_LD_DT    = 8'h07;
   localparam logic [7:0] NN_LD_KEY   = 8'h0A;
   localparam logic [7:0] NN_SET_DT   = 8'h15;
   localparam logic [7:0] NN_SET_ST   = 8'h18;
   localparam logic [7:0] NN_ADD_I    = 8'h1E;
   localparam logic [7:0] NN_BCD      = 8'h33;

   localparam logic [11:0] PC_RESET = 12'h200;
   localparam logic [11:0] PC_STEP  = 12'd2;

   // one accepted instruction
   typedef struct packed {
      logic [15:0] opcode;
      logic [3:0]  key_code;
      logic [7:0]  random_byte;
   } req_item_type;

   // architectural state outside the register file
   typedef struct packed {
      logic [11:0] pc;
      logic [11:0] index;
      logic [7:0]  delay_timer;
      logic [7:0]  sound_timer;
   } arch_state_type;

   // one result item
   typedef struct packed {
      logic [11:0] next_pc;
      logic [11:0] index_value;
      logic        bcd_write;
      logic [1:0]  bcd_hundreds;
      logic [3:0]  bcd_tens;
      logic [3:0]  bcd_ones;
      logic        clear_screen;
      logic [7:0]  delay_timer_value;
      logic [7:0]  sound_timer_value;
   } result_type;

   // register file write request: VX and the flag
   typedef struct packed {
      logic       reg_en;
      logic [3:0] reg_addr;
      logic [7:0] reg_data;
      logic       flag_en;
      logic       flag_data;
   } rf_wr_type;

endpackage

// File: rtl/chip8ie_channels.sv
// Handshake channel interfaces of the instruction execute unit
`timescale 1ns / 1ps
interface chip8ie_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] opcode;
   logic [3:0]  key_code;
   logic [7:0]  random_byte;
   modport source (output valid, opcode, key_code, random_byte, input ready);
   modport sink (input valid, opcode, key_code, random_byte, output ready);
endinterface

interface chip8ie_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] next_pc;
   logic [11:0] index_value;
   logic        bcd_write;
   logic [1:0]  bcd_hundreds;
   logic [3:0]  bcd_tens;
   logic [3:0]  bcd_ones;
   logic        clear_screen;
   logic [7:0]  delay_timer_value;
   logic [7:0]  sound_timer_value;
   modport source (output valid, next_pc, index_value, bcd_write, bcd_hundreds, bcd_tens,
                   bcd_ones, clear_screen, delay_timer_value, sound_timer_value,
                   input ready);
   modport sink (input valid, next_pc, index_value, bcd_write, bcd_hundreds, bcd_tens,
                 bcd_ones, clear_screen, delay_timer_value, sound_timer_value,
                 output ready);
endinterface

interface chip8ie_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] program_start;
   modport source (output valid, program_start, input ready);
   modport sink (input valid, program_start, output ready);
endinterface

// File: rtl/chip8ie_regfile.sv
// V register file: synchronous two-read memory, flag register and write forwarding
`timescale 1ns / 1ps
module chip8ie_regfile #(
   parameter int REGISTER_COUNT = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [$clog2(REGISTER_COUNT)-1:0] rd_a_addr,
   input  logic [$clog2(REGISTER_COUNT)-1:0] rd_b_addr,
   input  chip8ie_pkg::rf_wr_type            wr,
   output logic [7:0]                        rd_a_data,
   output logic [7:0]                        rd_b_data
);

   localparam int AW = $clog2(REGISTER_COUNT);
   localparam logic [AW-1:0] FLAG_IDX = AW'(REGISTER_COUNT - 1);

   logic [7:0]              mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;
   logic [7:0]              rd_a_raw_ff;
   logic [7:0]              rd_b_raw_ff;
   logic [AW-1:0]           rd_a_addr_ff;
   logic [AW-1:0]           rd_b_addr_ff;
   logic [7:0]              vf_ff;
   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic [7:0]              fwd_data_ff;
   logic [AW-1:0]           wr_addr;
   logic                    mem_wr;

   // VF lives in its own register so one instruction needs one memory write
   assign wr_addr = wr.reg_addr[AW-1:0];
   assign mem_wr  = wr.reg_en && (wr_addr != FLAG_IDX);

   // memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= wr.reg_data;
      end
      if (rd_en) begin
         rd_a_raw_ff  <= mem[rd_a_addr];
         rd_b_raw_ff  <= mem[rd_b_addr];
         rd_a_addr_ff <= rd_a_addr;
         rd_b_addr_ff <= rd_b_addr;
      end
   end

   // valid bits, flag register and last-write capture
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         vf_ff        <= 8'd0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (mem_wr) begin
            valid_ff[wr_addr] <= 1'b1;
            fwd_valid_ff      <= 1'b1;
            fwd_addr_ff       <= wr_addr;
            fwd_data_ff       <= wr.reg_data;
         end
         // flag written last so it wins over VX when X is F
         if (wr.flag_en) begin
            vf_ff <= {7'd0, wr.flag_data};
         end else if (wr.reg_en && (wr_addr == FLAG_IDX)) begin
            vf_ff <= wr.reg_data;
         end
      end
   end

   // read that met a write in the same cycle takes the forwarded value
   function automatic logic [7:0] resolve(input logic [AW-1:0] addr,
                                          input logic [7:0]    raw,
                                          input logic [7:0]    vf,
                                          input logic          fwd_v,
                                          input logic [AW-1:0] fwd_a,
                                          input logic [7:0]    fwd_d,
                                          input logic          ent_v);
      logic [7:0] val;
      if (addr == FLAG_IDX) begin
         val = vf;
      end else if (fwd_v && (fwd_a == addr)) begin
         val = fwd_d;
      end else if (ent_v) begin
         val = raw;
      end else begin
         val = 8'd0;
      end
      return val;
   endfunction

   assign rd_a_data = resolve(rd_a_addr_ff, rd_a_raw_ff, vf_ff, fwd_valid_ff, fwd_addr_ff,
                              fwd_data_ff, valid_ff[rd_a_addr_ff]);
   assign rd_b_data = resolve(rd_b_addr_ff, rd_b_raw_ff, vf_ff, fwd_valid_ff, fwd_addr_ff,
                              fwd_data_ff, valid_ff[rd_b_addr_ff]);

endmodule

// File: rtl/chip8ie_exec.sv
// Instruction decode and execute: next PC, index, timers, BCD and register writes
`timescale 1ns / 1ps
module chip8ie_exec (
   input  chip8ie_pkg::req_item_type   item,
   input  logic [7:0]                  vx,
   input  logic [7:0]                  vy,
   input  chip8ie_pkg::arch_state_type state,
   output chip8ie_pkg::result_type     result,
   output chip8ie_pkg::rf_wr_type      wr
);

   // binary to BCD by shift-add-3, eight steps on a narrow word
   function automatic logic [9:0] to_bcd(input logic [7:0] bin);
      logic [17:0] sh;
      sh = {10'd0, bin};
      for (int i = 0; i < 8; i++) begin
         if (sh[11:8] >= 4'd5) begin
            sh[11:8] = sh[11:8] + 4'd3;
         end
         if (sh[15:12] >= 4'd5) begin
            sh[15:12] = sh[15:12] + 4'd3;
         end
         sh = {sh[16:0], 1'b0};
      end
      return sh[17:8];
   endfunction

   chip8ie_pkg::op_group_type group;
   logic [3:0]  x;
   logic [3:0]  n;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic [11:0] pc_base;
   logic        skip;
   logic [8:0]  sum9;
   logic [9:0]  bcd;

   assign group = chip8ie_pkg::op_group_type'(item.opcode[15:12]);
   assign x     = item.opcode[11:8];
   assign n     = item.opcode[3:0];
   assign nn    = item.opcode[7:0];
   assign nnn   = item.opcode[11:0];
   assign sum9  = {1'b0, vx} + {1'b0, vy};
   assign bcd   = to_bcd(vx);

   // decode and execute
   always_comb begin
      pc_base = state.pc + chip8ie_pkg::PC_STEP;
      skip    = 1'b0;
      wr      = '0;
      wr.reg_addr = x;
      result  = '0;
      result.index_value       = state.index;
      result.delay_timer_value = state.delay_timer;
      result.sound_timer_value = state.sound_timer;
      case (group)
         chip8ie_pkg::OP_SYS: begin
            result.clear_screen = (nn == chip8ie_pkg::NN_CLS);
         end
         chip8ie_pkg::OP_JP: begin
            pc_base = nnn;
         end
         chip8ie_pkg::OP_SE_IMM:  skip = (vx == nn);
         chip8ie_pkg::OP_SNE_IMM: skip = (vx != nn);
         chip8ie_pkg::OP_SE_REG:  skip = (vx == vy);
         chip8ie_pkg::OP_SNE_REG: skip = (vx != vy);
         chip8ie_pkg::OP_LD_IMM: begin
            wr.reg_en   = 1'b1;
            wr.reg_data = nn;
         end
         chip8ie_pkg::OP_ADD_IMM: begin
            wr.reg_en   = 1'b1;
            wr.reg_data = vx + nn;
         end
         chip8ie_pkg::OP_ALU: begin
            case (n)
               chip8ie_pkg::ALU_MOV: begin
                  wr.reg_en   = 1'b1;
                  wr.reg_data = vy;
               end
               chip8ie_pkg::ALU_OR: begin
                  wr.reg_en   = 1'b1;
                  wr.reg_data = vx | vy;
               end
               chip8ie_pkg::ALU_AND: begin
                  wr.reg_en   = 1'b1;
                  wr.reg_data = vx & vy;
               end
               chip8ie_pkg::ALU_XOR: begin
                  wr.reg_en   = 1'b1;
                  wr.reg_data = vx ^ vy;
               end
               chip8ie_pkg::ALU_ADD: begin
                  wr.reg_en    = 1'b1;
                  wr.reg_data  = sum9[7:0];
                  wr.flag_en   = 1'b1;
                  wr.flag_data = sum9[8];
               end
               chip8ie_pkg::ALU_SUB: begin
                  wr.reg_en    = 1'b1;
                  wr.reg_data  = vx - vy;
                  wr.flag_en   = 1'b1;
                  wr.flag_data = (vx >= vy);
               end
               chip8ie_pkg::ALU_SHR: begin
                  wr.reg_en    = 1'b1;
                  wr.reg_data  = {1'b0, vx[7:1]};
                  wr.flag_en   = 1'b1;
                  wr.flag_data = vx[0];
               end
               chip8ie_pkg::ALU_SUBN: begin
                  wr.reg_en    = 1'b1;
                  wr.reg_data  = vy - vx;
                  wr.flag_en   = 1'b1;
                  wr.flag_data = (vy >= vx);
               end
               chip8ie_pkg::ALU_SHL: begin
                  wr.reg_en    = 1'b1;
                  wr.reg_data  = {vx[6:0], 1'b0};
                  wr.flag_en   = 1'b1;
                  wr.flag_data = vx[7];
               end
               default: begin
               end
            endcase
         end
         chip8ie_pkg::OP_LD_I: begin
            result.index_value = nnn;
         end
         chip8ie_pkg::OP_JP_V0: begin
            // read port A carries V0 for this group
            pc_base = nnn + {4'd0, vx};
         end
         chip8ie_pkg::OP_RND: begin
            wr.reg_en   = 1'b1;
            wr.reg_data = item.random_byte & nn;
         end
         chip8ie_pkg::OP_KEY: begin
            if (nn == chip8ie_pkg::NN_SKP) begin
               skip = (vx == {4'd0, item.key_code});
            end else if (nn == chip8ie_pkg::NN_SKNP) begin
               skip = (vx != {4'd0, item.key_code});
            end
         end
         chip8ie_pkg::OP_MISC: begin
            case (nn)
               chip8ie_pkg::NN_LD_DT: begin
                  wr.reg_en   = 1'b1;
                  wr.reg_data = state.delay_timer;
               end
               chip8ie_pkg::NN_LD_KEY: begin
                  wr.reg_en   = 1'b1;
                  wr.reg_data = {4'd0, item.key_code};
               end
               chip8ie_pkg::NN_SET_DT: result.delay_timer_value = vx;
               chip8ie_pkg::NN_SET_ST: result.sound_timer_value = vx;
               chip8ie_pkg::NN_ADD_I: begin
                  result.index_value = state.index + {4'd0, vx};
               end
               chip8ie_pkg::NN_BCD: begin
                  result.bcd_write    = 1'b1;
                  result.bcd_hundreds = bcd[9:8];
                  result.bcd_tens     = bcd[7:4];
                  result.bcd_ones     = bcd[3:0];
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      result.next_pc = skip ? (pc_base + chip8ie_pkg::PC_STEP) : pc_base;
   end

endmodule

// File: rtl/chip8_instruction_execute_unit.sv
// Top level of the CHIP-8 instruction execute unit
//
// channel   direction  transfer when        payload
// req_chan  in         valid && ready       opcode, key_code, random_byte
// rsp_chan  out        valid && ready       next_pc, index, BCD digits, clear, timers
// csr_chan  in         valid && ready       program_start (also reloads the PC)
//
// One instruction per cycle sustained while rsp_chan is not stalled. The V registers
// are read from the register file memory at the transfer edge, as the instruction
// enters the execute stage register; it executes from there into the output register.
// A write-forwarding register covers a read that meets the previous write.
// Reset clears the register file valid bits at once, with no clearing pass.
// While the output register waits, the execute stage holds and req ready drops
// only when that stage is also full.
`timescale 1ns / 1ps
`include "chip8_instruction_execute_unit_assert.svh"
module chip8_instruction_execute_unit #(
   parameter int REGISTER_COUNT = 16
) (
   input logic           clock,
   input logic           reset,
   chip8ie_req_if.sink   req_chan,
   chip8ie_rsp_if.source rsp_chan,
   chip8ie_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(REGISTER_COUNT);

   logic                        req_xfer;
   logic                        exec;
   logic                        s1_valid_ff;
   chip8ie_pkg::req_item_type   s1_item_ff;
   chip8ie_pkg::arch_state_type state_ff;
   chip8ie_pkg::result_type     result;
   chip8ie_pkg::result_type     rsp_result_ff;
   logic                        rsp_valid_ff;
   chip8ie_pkg::rf_wr_type      exec_wr;
   chip8ie_pkg::rf_wr_type      rf_wr;
   logic [AW-1:0]               rd_a_addr;
   logic [AW-1:0]               rd_b_addr;
   logic [7:0]                  rd_a_data;
   logic [7:0]                  rd_b_data;

   // handshake
   assign exec           = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || exec;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // operand addresses: BNNN reads V0 on port A
   assign rd_a_addr = (chip8ie_pkg::op_group_type'(req_chan.opcode[15:12]) ==
                       chip8ie_pkg::OP_JP_V0) ? '0 : req_chan.opcode[8+AW-1:8];
   assign rd_b_addr = req_chan.opcode[4+AW-1:4];

   // register writes only from an executing instruction
   always_comb begin
      rf_wr         = exec_wr;
      rf_wr.reg_en  = exec_wr.reg_en && exec;
      rf_wr.flag_en = exec_wr.flag_en && exec;
   end

   chip8ie_regfile #(
      .REGISTER_COUNT(REGISTER_COUNT)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_xfer),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .wr        (rf_wr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   chip8ie_exec u_exec (
      .item   (s1_item_ff),
      .vx     (rd_a_data),
      .vy     (rd_b_data),
      .state  (state_ff),
      .result (result),
      .wr     (exec_wr)
   );

   // execute stage holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_xfer) begin
         s1_item_ff.opcode      <= req_chan.opcode;
         s1_item_ff.key_code    <= req_chan.key_code;
         s1_item_ff.random_byte <= req_chan.random_byte;
      end
   end

   // PC, index and timers; a configuration write restarts the PC
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pc          <= chip8ie_pkg::PC_RESET;
         state_ff.index       <= '0;
         state_ff.delay_timer <= '0;
         state_ff.sound_timer <= '0;
      end else if (csr_chan.valid) begin
         state_ff.pc <= csr_chan.program_start;
      end else if (exec) begin
         state_ff.pc          <= result.next_pc;
         state_ff.index       <= result.index_value;
         state_ff.delay_timer <= result.delay_timer_value;
         state_ff.sound_timer <= result.sound_timer_value;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (exec) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.next_pc           = rsp_result_ff.next_pc;
   assign rsp_chan.index_value       = rsp_result_ff.index_value;
   assign rsp_chan.bcd_write         = rsp_result_ff.bcd_write;
   assign rsp_chan.bcd_hundreds      = rsp_result_ff.bcd_hundreds;
   assign rsp_chan.bcd_tens          = rsp_result_ff.bcd_tens;
   assign rsp_chan.bcd_ones          = rsp_result_ff.bcd_ones;
   assign rsp_chan.clear_screen      = rsp_result_ff.clear_screen;
   assign rsp_chan.delay_timer_value = rsp_result_ff.delay_timer_value;
   assign rsp_chan.sound_timer_value = rsp_result_ff.sound_timer_value;

   // checks
   `CHIP8_ASSERT_CLK(a_exec_fills_output, exec |=> rsp_valid_ff, "executed result not presented")
   `CHIP8_ASSERT_CLK(a_blocked_no_accept, (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready, "transfer accepted into a blocked stage")
   `CHIP8_ASSERT_CLK(a_bcd_clear_exclusive, rsp_valid_ff |-> !(rsp_result_ff.bcd_write && rsp_result_ff.clear_screen), "BCD and clear in one result")
   `CHIP8_ASSERT_CLK(a_digits_idle_zero, (rsp_valid_ff && !rsp_result_ff.bcd_write) |-> (rsp_result_ff.bcd_hundreds == 2'd0 && rsp_result_ff.bcd_tens == 4'd0 && rsp_result_ff.bcd_ones == 4'd0), "BCD digits set without a BCD request")
   `CHIP8_ASSERT_RST(a_reset_empties, $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule

// File: tb/chip8_instruction_execute_unit_tb.sv
// Self-checking testbench for the CHIP-8 instruction execute unit
`timescale 1ns / 1ps
module chip8_instruction_execute_unit_tb;
   import chip8ie_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 300;
   localparam int PHASE_COUNT  = 6;
   localparam int REPORT_LIMIT = 10;
   localparam logic [3:0] FLAG_REG = 4'hF;

   localparam logic [3:0] ALU_CODES [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                           ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};
   localparam logic [7:0] MISC_CODES [6] = '{NN_LD_DT, NN_LD_KEY, NN_SET_DT, NN_SET_ST,
                                            NN_ADD_I, NN_BCD};
   localparam logic [7:0] BYTE_EDGES [8] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF,
                                            8'd99, 8'd100};

   typedef struct {
      req_item_type item;
      bit           drain_first;   // hold off until every result is back
   } instr_entry_type;

   logic clock;
   logic reset;

   chip8ie_req_if req_chan ();
   chip8ie_rsp_if rsp_chan ();
   chip8ie_csr_if csr_chan ();

   chip8_instruction_execute_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow copy of the architectural state
   logic [7:0]      shadow_v [16];
   arch_state_type  shadow_arch;

   instr_entry_type instr_queue [$];
   result_type      due_results [$];
   req_item_type    in_flight;
   int              sent_count;
   int              rcvd_count;
   int              mismatches;
   int              cycle_count;
   int              tx_gap, tx_calm, rx_stall, rx_calm;
   result_type      want, got;

   always #5 clock = ~clock;

   // gap length: mostly short, a few long, and now and then a calm stretch
   function automatic int pause_length(inout int calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm = $urandom_range(30, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // byte operand biased towards small values and boundaries
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 15));
         1: return BYTE_EDGES[$urandom_range(0, 7)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // executes one instruction on the shadow state and returns the expected result
   function automatic result_type execute_instruction(req_item_type it);
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, alu_res;
      logic [8:0]  sum;
      logic [11:0] pc;
      logic        skip, flag, flag_write;
      result_type  r;
      x          = it.opcode[11:8];
      y          = it.opcode[7:4];
      n          = it.opcode[3:0];
      nn         = it.opcode[7:0];
      vx         = shadow_v[x];
      vy         = shadow_v[y];
      pc         = shadow_arch.pc + PC_STEP;
      skip       = 1'b0;
      flag       = 1'b0;
      flag_write = 1'b0;
      alu_res    = vx;
      r          = '0;
      case (op_group_type'(it.opcode[15:12]))
         OP_SYS:     r.clear_screen = (nn == NN_CLS);
         OP_JP:      pc = it.opcode[11:0];
         OP_SE_IMM:  skip = (vx == nn);
         OP_SNE_IMM: skip = (vx != nn);
         OP_SE_REG:  skip = (vx == vy);
         OP_LD_IMM:  shadow_v[x] = nn;
         OP_ADD_IMM: shadow_v[x] = vx + nn;
         OP_ALU: begin
            case (n)
               ALU_MOV: shadow_v[x] = vy;
               ALU_OR:  shadow_v[x] = vx | vy;
               ALU_AND: shadow_v[x] = vx & vy;
               ALU_XOR: shadow_v[x] = vx ^ vy;
               ALU_ADD: begin
                  sum        = {1'b0, vx} + {1'b0, vy};
                  alu_res    = sum[7:0];
                  flag       = sum[8];
                  flag_write = 1'b1;
               end
               ALU_SUB: begin
                  alu_res    = vx - vy;
                  flag       = (vx >= vy);
                  flag_write = 1'b1;
               end
               ALU_SHR: begin
                  alu_res    = vx >> 1;
                  flag       = vx[0];
                  flag_write = 1'b1;
               end
               ALU_SUBN: begin
                  alu_res    = vy - vx;
                  flag       = (vy >= vx);
                  flag_write = 1'b1;
               end
               ALU_SHL: begin
                  alu_res    = vx << 1;
                  flag       = vx[7];
                  flag_write = 1'b1;
               end
               default: ;
            endcase
            // flag goes in last so it wins when X is the flag register
            if (flag_write) begin
               shadow_v[x]        = alu_res;
               shadow_v[FLAG_REG] = {7'b0, flag};
            end
         end
         OP_SNE_REG: skip = (vx != vy);
         OP_LD_I:    shadow_arch.index = it.opcode[11:0];
         OP_JP_V0:   pc = it.opcode[11:0] + {4'h0, shadow_v[0]};
         OP_RND:     shadow_v[x] = it.random_byte & nn;
         OP_KEY: begin
            if (nn == NN_SKP) skip = (vx == {4'h0, it.key_code});
            else if (nn == NN_SKNP) skip = (vx != {4'h0, it.key_code});
         end
         OP_MISC: begin
            case (nn)
               NN_LD_DT:  shadow_v[x] = shadow_arch.delay_timer;
               NN_LD_KEY: shadow_v[x] = {4'h0, it.key_code};
               NN_SET_DT: shadow_arch.delay_timer = vx;
               NN_SET_ST: shadow_arch.sound_timer = vx;
               NN_ADD_I:  shadow_arch.index = shadow_arch.index + {4'h0, vx};
               NN_BCD: begin
                  r.bcd_write    = 1'b1;
                  r.bcd_hundreds = 2'(vx / 100);
                  r.bcd_tens     = 4'((vx / 10) % 10);
                  r.bcd_ones     = 4'(vx % 10);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (skip) pc = pc + PC_STEP;
      shadow_arch.pc      = pc;
      r.next_pc           = pc;
      r.index_value       = shadow_arch.index;
      r.delay_timer_value = shadow_arch.delay_timer;
      r.sound_timer_value = shadow_arch.sound_timer;
      return r;
   endfunction

   // wait until the sender is empty and every result is back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (instr_queue.size() != 0 || req_chan.valid || sent_count != rcvd_count);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // instruction driver
   always @(posedge clock) begin
      instr_entry_type next_entry;
      if (reset) begin
         req_chan.valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            due_results.push_back(execute_instruction(in_flight));
            sent_count++;
            tx_gap = pause_length(tx_calm);
         end
         if (req_chan.valid && !req_chan.ready) begin
            // transfer still pending: hold
         end else if (tx_gap > 0 || instr_queue.size() == 0 ||
                      (instr_queue[0].drain_first && sent_count != rcvd_count)) begin
            if (tx_gap > 0) tx_gap--;
            req_chan.valid       <= 1'b0;
            req_chan.opcode      <= 16'($urandom_range(0, 65535));
            req_chan.key_code    <= 4'($urandom_range(0, 15));
            req_chan.random_byte <= 8'($urandom_range(0, 255));
         end else begin
            next_entry = instr_queue.pop_front();
            in_flight  = next_entry.item;
            req_chan.valid       <= 1'b1;
            req_chan.opcode      <= in_flight.opcode;
            req_chan.key_code    <= in_flight.key_code;
            req_chan.random_byte <= in_flight.random_byte;
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rcvd_count <= rcvd_count + 1;
            got.next_pc           = rsp_chan.next_pc;
            got.index_value       = rsp_chan.index_value;
            got.bcd_write         = rsp_chan.bcd_write;
            got.bcd_hundreds      = rsp_chan.bcd_hundreds;
            got.bcd_tens          = rsp_chan.bcd_tens;
            got.bcd_ones          = rsp_chan.bcd_ones;
            got.clear_screen      = rsp_chan.clear_screen;
            got.delay_timer_value = rsp_chan.delay_timer_value;
            got.sound_timer_value = rsp_chan.sound_timer_value;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result with nothing outstanding, pc=%h",
                           $realtime, got.next_pc);
            end else begin
               want = due_results.pop_front();
               if (got.next_pc !== want.next_pc || got.index_value !== want.index_value ||
                   got.bcd_write !== want.bcd_write ||
                   got.bcd_hundreds !== want.bcd_hundreds ||
                   got.bcd_tens !== want.bcd_tens || got.bcd_ones !== want.bcd_ones ||
                   got.clear_screen !== want.clear_screen ||
                   got.delay_timer_value !== want.delay_timer_value ||
                   got.sound_timer_value !== want.sound_timer_value) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: mismatch exp pc=%h i=%h bcd=%b %0d%0d%0d cls=%b dt=%h st=%h",
                               " | got pc=%h i=%h bcd=%b %0d%0d%0d cls=%b dt=%h st=%h"},
                              $realtime, want.next_pc, want.index_value, want.bcd_write,
                              want.bcd_hundreds, want.bcd_tens, want.bcd_ones,
                              want.clear_screen, want.delay_timer_value,
                              want.sound_timer_value, got.next_pc, got.index_value,
                              got.bcd_write, got.bcd_hundreds, got.bcd_tens, got.bcd_ones,
                              got.clear_screen, got.delay_timer_value,
                              got.sound_timer_value);
               end
            end
            rx_stall = pause_length(rx_calm);
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      logic [19:0]     directed_items [29];
      logic [11:0]     start_addr [PHASE_COUNT];
      instr_entry_type entry;
      logic [3:0]      grp;
      logic [15:0]     op;

      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.opcode       = '0;
      req_chan.key_code     = '0;
      req_chan.random_byte  = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.program_start = PC_RESET;
      sent_count = 0;
      rcvd_count = 0;
      mismatches = 0;
      cycle_count = 0;
      tx_calm = 0;
      rx_calm = 0;
      foreach (shadow_v[i]) shadow_v[i] = '0;
      shadow_arch = '{pc: PC_RESET, index: '0, delay_timer: '0, sound_timer: '0};

      // opcode, key: extremes, a selection of operations, flag-register and wrap cases
      directed_items = '{
         {16'h00E0, 4'h0}, {16'h00EE, 4'h0}, {16'h60FF, 4'h0}, {16'h6101, 4'h0},
         {16'h8014, 4'h0}, {16'h8015, 4'h0}, {16'h8017, 4'h0}, {16'h8016, 4'h0},
         {16'h6FC8, 4'h0}, {16'h8FFE, 4'h0}, {16'h7FFF, 4'h0}, {16'h501F, 4'h0},
         {16'h3001, 4'h0}, {16'hAFFF, 4'h0}, {16'hF11E, 4'h0}, {16'hBFFF, 4'h0},
         {16'h1FFE, 4'h0}, {16'h630A, 4'h0}, {16'hE39E, 4'hA}, {16'hE3A1, 4'h5},
         {16'hC2FF, 4'h0}, {16'hF50A, 4'hF}, {16'hF515, 4'h0}, {16'hF618, 4'h0},
         {16'hF707, 4'h0}, {16'h68FF, 4'h0}, {16'hF833, 4'h0}, {16'hD123, 4'h0},
         {16'hF0FF, 4'h0}};
      start_addr = '{12'hFFE, 12'h000, 12'hFFF, 12'($urandom_range(0, 4095)), PC_RESET,
                     12'($urandom_range(0, 4095))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part from the reset start address
      @(negedge clock);
      foreach (directed_items[i]) begin
         entry.item.opcode      = directed_items[i][19:4];
         entry.item.key_code    = directed_items[i][3:0];
         entry.item.random_byte = 8'($urandom_range(0, 255));
         entry.drain_first      = 1'b0;
         instr_queue.push_back(entry);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_until_drained();

         // new start address, reloads the PC
         @(posedge clock);
         csr_chan.valid         <= 1'b1;
         csr_chan.program_start <= start_addr[p];
         do @(posedge clock);
         while (!(csr_chan.valid && csr_chan.ready));
         shadow_arch.pc = start_addr[p];
         csr_chan.valid <= 1'b0;

         @(negedge clock);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            grp = 4'($urandom_range(0, 15));
            op  = {grp, 12'($urandom_range(0, 4095))};
            case (op_group_type'(grp))
               OP_SYS:
                  if ($urandom_range(0, 2) != 0) op[7:0] = NN_CLS;
               OP_SE_IMM, OP_SNE_IMM, OP_LD_IMM, OP_ADD_IMM, OP_RND:
                  op[7:0] = pick_byte();
               OP_ALU:
                  if ($urandom_range(0, 9) != 0) op[3:0] = ALU_CODES[$urandom_range(0, 8)];
               OP_KEY:
                  if ($urandom_range(0, 9) != 0)
                     op[7:0] = $urandom_range(0, 1) ? NN_SKP : NN_SKNP;
               OP_MISC:
                  if ($urandom_range(0, 9) != 0) op[7:0] = MISC_CODES[$urandom_range(0, 5)];
               default: ;
            endcase
            entry.item.opcode      = op;
            entry.item.key_code    = 4'($urandom_range(0, 15));
            entry.item.random_byte = 8'($urandom_range(0, 255));
            entry.drain_first      = (k == PHASE_ITEMS / 2) || ($urandom_range(0, 199) == 0);
            instr_queue.push_back(entry);
         end
      end

      wait_until_drained();
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/chip8ie_pkg.sv
rtl/chip8ie_channels.sv
rtl/chip8ie_regfile.sv
rtl/chip8ie_exec.sv
rtl/chip8_instruction_execute_unit.sv
tb/chip8_instruction_execute_unit_tb.sv
